>>> hdl/hsog_pkg.sv
// Shared constants and types for the Hadamard sequency order generator.
// No dependencies; used by hsog_row_check and the top level.
package hsog_pkg;

	localparam int MAX_SIZE_LOG2 = 8;
	localparam int SIZE_W = 4;
	localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;
	localparam int IDX_W = 8;
	localparam int SEQ_W = 9;
	localparam int POS_W = 16;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_SEARCH
	} state_t;

	typedef struct packed {
		logic hit;
		logic set_wrap;
	} chk_status_t;

endpackage

>>> hdl/hsog_row_check.sv
// Row check unit: advances the walk past an exhausted row or key and tests
// one row against the current key. Depends on hsog_pkg.
module hsog_row_check #(
	parameter int MAX_SIZE_LOG2 = hsog_pkg::MAX_SIZE_LOG2
) (
	input  logic [MAX_SIZE_LOG2:0] row,
	input  logic [MAX_SIZE_LOG2:0] key,
	input  logic [MAX_SIZE_LOG2:0] n,
	input  logic [MAX_SIZE_LOG2:0] kmax,
	output logic [MAX_SIZE_LOG2:0] row_chk,
	output logic [MAX_SIZE_LOG2:0] key_chk,
	output logic [MAX_SIZE_LOG2:0] diff,
	output hsog_pkg::chk_status_t  status
);

	localparam int RW = MAX_SIZE_LOG2 + 1;

	logic [RW-1:0] gray;

	always_comb begin
		row_chk = row;
		key_chk = key;
		status.set_wrap = 1'b0;
		if (row >= n) begin
			row_chk = '0;
			key_chk = key + RW'(1);
		end
		if (key_chk > kmax) begin
			row_chk = '0;
			key_chk = '0;
			status.set_wrap = 1'b1;
		end
		gray = row_chk ^ (row_chk >> 1);
		diff = key_chk - gray;
		status.hit = (key_chk >= gray) && (diff < n);
	end

endmodule

>>> hdl/hadamard_sequency_order_generator_core.sv
// Top level of the Hadamard sequency order generator: walk sequencer,
// size register and result register. Depends on hsog_pkg and hsog_row_check.
//
//  channel   direction  handshake            payload
//  in        input      in_valid/in_ready    restart
//  out       output     out_valid/out_ready  u_index v_index sequency position last
//  cfg       input      cfg_wr_en            cfg_wr_data (size_log2)
//
// An item is accepted in ST_IDLE; ST_SEARCH then tests rows with the shared
// row check unit until a hit is found that the result register can take.
// The result register takes a new result only when empty or being drained.
// Reset clears the walk and sets size_log2 to 8; no clearing pass.
module hadamard_sequency_order_generator_core #(
	parameter int MAX_SIZE_LOG2 = hsog_pkg::MAX_SIZE_LOG2
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [hsog_pkg::SIZE_W-1:0]   cfg_wr_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          restart,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [hsog_pkg::IDX_W-1:0]    u_index,
	output logic [hsog_pkg::IDX_W-1:0]    v_index,
	output logic [hsog_pkg::SEQ_W-1:0]    sequency,
	output logic [hsog_pkg::POS_W-1:0]    position,
	output logic                          last
);

	localparam int RW = MAX_SIZE_LOG2 + 1;
	localparam int LW = $clog2(MAX_SIZE_LOG2 + 1);
	localparam logic [LW-1:0] MAX_LG = LW'(MAX_SIZE_LOG2);
	localparam logic [hsog_pkg::SIZE_W-1:0] MAX_SZ = hsog_pkg::SIZE_W'(MAX_SIZE_LOG2);

	hsog_pkg::state_t state_q, state_d;
	logic [hsog_pkg::SIZE_W-1:0] size_q;
	logic [RW-1:0] key_q, row_q;
	logic [hsog_pkg::POS_W-1:0] cnt_q;
	logic out_valid_q;
	logic [hsog_pkg::IDX_W-1:0] u_q, v_q;
	logic [hsog_pkg::SEQ_W-1:0] seq_q;
	logic [hsog_pkg::POS_W-1:0] pos_q;
	logic last_q;

	logic [LW-1:0] lg;
	logic [RW-1:0] n, kmax;
	logic [RW-1:0] row_chk, key_chk, diff;
	hsog_pkg::chk_status_t status;
	logic [hsog_pkg::POS_W-1:0] cnt_chk;
	logic [RW-1:0] row_inc;
	logic [MAX_SIZE_LOG2-1:0] col, row_rev, col_rev;
	logic is_last, load_out, accept;

	assign lg = (size_q > MAX_SZ) ? MAX_LG : size_q[LW-1:0];
	assign n = RW'(1) << lg;
	assign kmax = (n - RW'(1)) << 1;

	hsog_row_check #(
		.MAX_SIZE_LOG2(MAX_SIZE_LOG2)
	) u_row_check (
		.row    (row_q),
		.key    (key_q),
		.n      (n),
		.kmax   (kmax),
		.row_chk(row_chk),
		.key_chk(key_chk),
		.diff   (diff),
		.status (status)
	);

	always_comb begin
		for (int i = 0; i < MAX_SIZE_LOG2; i++) begin
			col[i] = ^(diff[MAX_SIZE_LOG2-1:0] >> i);
		end
		for (int i = 0; i < MAX_SIZE_LOG2; i++) begin
			row_rev[i] = row_chk[MAX_SIZE_LOG2-1-i];
			col_rev[i] = col[MAX_SIZE_LOG2-1-i];
		end
		row_rev = row_rev >> (MAX_LG - lg);
		col_rev = col_rev >> (MAX_LG - lg);
	end

	assign cnt_chk = status.set_wrap ? '0 : cnt_q;
	assign row_inc = row_chk + RW'(1);
	assign is_last = (key_chk == kmax);
	assign accept = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		load_out = 1'b0;
		in_ready = 1'b0;
		unique case (state_q)
			hsog_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = hsog_pkg::ST_SEARCH;
				end
			end
			hsog_pkg::ST_SEARCH: begin
				if (status.hit && (!out_valid_q || out_ready)) begin
					load_out = 1'b1;
					state_d = hsog_pkg::ST_IDLE;
				end
			end
			default: state_d = hsog_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hsog_pkg::ST_IDLE;
			size_q <= hsog_pkg::SIZE_RESET;
			key_q <= '0;
			row_q <= '0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				size_q <= cfg_wr_data;
			end
			if (accept && restart) begin
				key_q <= '0;
				row_q <= '0;
				cnt_q <= '0;
			end else if (state_q == hsog_pkg::ST_SEARCH) begin
				if (!status.hit) begin
					key_q <= key_chk;
					row_q <= row_inc;
					cnt_q <= cnt_chk;
				end else if (load_out) begin
					if (is_last) begin
						key_q <= '0;
						row_q <= '0;
						cnt_q <= '0;
					end else begin
						if (row_inc >= n) begin
							row_q <= '0;
							key_q <= key_chk + RW'(1);
						end else begin
							row_q <= row_inc;
							key_q <= key_chk;
						end
						cnt_q <= cnt_chk + hsog_pkg::POS_W'(1);
					end
				end
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			u_q <= hsog_pkg::IDX_W'(row_rev);
			v_q <= hsog_pkg::IDX_W'(col_rev);
			seq_q <= hsog_pkg::SEQ_W'(key_chk);
			pos_q <= cnt_chk;
			last_q <= is_last;
		end
	end

	assign out_valid = out_valid_q;
	assign u_index = u_q;
	assign v_index = v_q;
	assign sequency = seq_q;
	assign position = pos_q;
	assign last = last_q;

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("item taken while previous item still searching");

	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && restart |=> key_q == '0 && row_q == '0 && cnt_q == '0)
		else $error("restart did not clear walk state");

	a_index_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (u_q >> lg) == '0 && (v_q >> lg) == '0)
		else $error("pattern index outside grid");
`endif

endmodule
